[sv/spk_pkg.sv]
// ----------------------------------------------------------------------------
// spk_pkg
// Shared types and constants for the Speck32/64 cipher block.
// ----------------------------------------------------------------------------
package spk_pkg;

	localparam int WORD_W    = 16;
	localparam int KEY_WORDS = 4;
	localparam int CFG_IDX_W = 2;
	localparam int ALPHA     = 7;
	localparam int BETA      = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 2'd3;

	typedef logic [WORD_W-1:0] word_t;

	// operands of one round
	typedef struct packed {
		logic  inv;
		word_t hi;
		word_t lo;
		word_t key;
	} round_in_t;

	typedef struct packed {
		word_t hi;
		word_t lo;
	} round_out_t;

endpackage

[sv/spk_if.sv]
// ----------------------------------------------------------------------------
// spk_in_if / spk_out_if
// Valid/ready channels for block words into and out of the cipher.
// ----------------------------------------------------------------------------
interface spk_in_if;
	logic          valid;
	logic          ready;
	logic          action;
	spk_pkg::word_t word0;
	spk_pkg::word_t word1;

	modport source (output valid, output action, output word0, output word1, input ready);
	modport sink (input valid, input action, input word0, input word1, output ready);
endinterface

interface spk_out_if;
	logic          valid;
	logic          ready;
	spk_pkg::word_t out_word0;
	spk_pkg::word_t out_word1;

	modport source (output valid, output out_word0, output out_word1, input ready);
	modport sink (input valid, input out_word0, input out_word1, output ready);
endinterface

[sv/spk_round.sv]
// ----------------------------------------------------------------------------
// spk_round
// One Speck round, forward or inverse, shared by key schedule and data path.
// ----------------------------------------------------------------------------
module spk_round (
	input  spk_pkg::round_in_t  rin,
	output spk_pkg::round_out_t rout
);

	spk_pkg::word_t hi_rot;
	spk_pkg::word_t fwd_hi;
	spk_pkg::word_t fwd_lo;
	spk_pkg::word_t mix;
	spk_pkg::word_t inv_lo;
	spk_pkg::word_t inv_sub;
	spk_pkg::word_t inv_hi;

	always_comb begin
		// forward: hi ror alpha, add lo, xor key; lo rol beta xor hi
		hi_rot = (rin.hi >> spk_pkg::ALPHA) | (rin.hi << (spk_pkg::WORD_W - spk_pkg::ALPHA));
		fwd_hi = (hi_rot + rin.lo) ^ rin.key;
		fwd_lo = ((rin.lo << spk_pkg::BETA) | (rin.lo >> (spk_pkg::WORD_W - spk_pkg::BETA)))
			^ fwd_hi;

		// inverse: undo the xor and rotate, then subtract and rotate back
		mix     = rin.lo ^ rin.hi;
		inv_lo  = (mix >> spk_pkg::BETA) | (mix << (spk_pkg::WORD_W - spk_pkg::BETA));
		inv_sub = (rin.hi ^ rin.key) - inv_lo;
		inv_hi  = (inv_sub << spk_pkg::ALPHA) | (inv_sub >> (spk_pkg::WORD_W - spk_pkg::ALPHA));

		if (rin.inv) begin
			rout.hi = inv_hi;
			rout.lo = inv_lo;
		end else begin
			rout.hi = fwd_hi;
			rout.lo = fwd_lo;
		end
	end

endmodule

[sv/spk_key_store.sv]
// ----------------------------------------------------------------------------
// spk_key_store
// Generic RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module spk_key_store #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 22
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// contents undefined until written
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[sv/speck32_64_block_cipher.sv]
// ----------------------------------------------------------------------------
// speck32_64_block_cipher
// Speck32/64 encrypt/decrypt engine with an on-chip round-key schedule.
// ----------------------------------------------------------------------------
// usage
//   cfg port: cfg_we/cfg_index/cfg_data write key words 0..3 (no read-back).
//     every key write marks the round keys stale; once writes stop the
//     block expands the key into NUM_ROUNDS round keys (key word 0 is
//     loaded as the first, then the shared round makes each next key) and
//     holds in_ch.ready low until that is done
//   in_ch: one word is one 32-bit block (word0 low, word1 high) plus the
//     action bit, 0 encrypt, 1 decrypt
//   out_ch: one result word per input word, in order
//   rounds: one round per cycle through the single shared round unit;
//     a new block is taken only after the previous block's result has
//     been loaded into the output register
//   the output register frees the engine: a block may be accepted while
//     the previous result waits; if the receiver still stalls when the
//     next block finishes, that block parks in the engine until taken
//   reset: keys read as zero, round keys are rebuilt before the first
//     block, no result pending
// ----------------------------------------------------------------------------
module speck32_64_block_cipher #(
	parameter int NUM_ROUNDS = 22
) (
	input  logic                             clk,
	input  logic                             arst_n,
	spk_in_if.sink                           in_ch,
	spk_out_if.source                        out_ch,
	input  logic                             cfg_we,
	input  logic [spk_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  spk_pkg::word_t                   cfg_data
);

	localparam int CNT_W = (NUM_ROUNDS > 1) ? $clog2(NUM_ROUNDS) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(NUM_ROUNDS - 1);
	localparam logic [CNT_W-1:0] SCHED_END = CNT_W'((NUM_ROUNDS > 1) ? NUM_ROUNDS - 2 : 0);

	// sequencer codes
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCHED = 2'd1;
	localparam logic [1:0] ST_RUN   = 2'd2;
	localparam logic [1:0] ST_HOLD  = 2'd3;

	logic [1:0]      state_q;
	logic            sched_ok_q;
	logic [CNT_W-1:0] cnt_q;
	logic            out_valid_q;

	spk_pkg::word_t  key_q [spk_pkg::KEY_WORDS];
	spk_pkg::word_t  cur_q;
	spk_pkg::word_t  lw_q [spk_pkg::KEY_WORDS-1];
	spk_pkg::word_t  hi_q;
	spk_pkg::word_t  lo_q;
	logic            dec_q;
	spk_pkg::word_t  ow0_q;
	spk_pkg::word_t  ow1_q;

	spk_pkg::round_in_t  rnd_in;
	spk_pkg::round_out_t rnd_out;

	logic            tbl_we;
	logic [CNT_W-1:0] tbl_waddr;
	spk_pkg::word_t  tbl_wdata;
	logic [CNT_W-1:0] tbl_raddr;
	spk_pkg::word_t  tbl_rdata;

	logic            in_fire;
	logic            out_free;
	logic            out_load;
	logic            sched_start;
	logic [CNT_W-1:0] cnt_inc;
	logic [CNT_W-1:0] rd_step;
	logic            rd_dec;

	assign in_ch.ready  = (state_q == ST_IDLE) && sched_ok_q;
	assign in_fire      = in_ch.valid && in_ch.ready;
	assign out_free     = !out_valid_q || out_ch.ready;
	// last round done (or parked block) and the output register can take it
	assign out_load     = (((state_q == ST_RUN) && (cnt_q == CNT_LAST)) || (state_q == ST_HOLD))
		&& out_free;
	// a write in the same cycle defers the start so the newest key is used
	assign sched_start  = (state_q == ST_IDLE) && !sched_ok_q && !cfg_we;
	assign cnt_inc      = cnt_q + CNT_W'(1);

	assign out_ch.valid     = out_valid_q;
	assign out_ch.out_word0 = ow0_q;
	assign out_ch.out_word1 = ow1_q;

	// the table read is registered, so the address runs ahead of the round:
	// the accept edge fetches the first key, each round fetches the next;
	// decrypt walks the table backwards
	assign rd_step   = (in_fire || (cnt_q == CNT_LAST)) ? '0 : cnt_inc;
	assign rd_dec    = in_fire ? in_ch.action : dec_q;
	assign tbl_raddr = rd_dec ? (CNT_LAST - rd_step) : rd_step;

	// round unit operands: schedule uses the key words, data uses the block
	always_comb begin
		if (state_q == ST_SCHED) begin
			rnd_in.inv = 1'b0;
			rnd_in.hi  = lw_q[0];
			rnd_in.lo  = cur_q;
			rnd_in.key = {{(spk_pkg::WORD_W - CNT_W){1'b0}}, cnt_q};
		end else begin
			rnd_in.inv = dec_q;
			rnd_in.hi  = hi_q;
			rnd_in.lo  = lo_q;
			rnd_in.key = tbl_rdata;
		end
	end

	// table writes: key word 0 at schedule start, then each new round key
	always_comb begin
		if (state_q == ST_SCHED) begin
			tbl_we    = 1'b1;
			tbl_waddr = cnt_inc;
			tbl_wdata = rnd_out.lo;
		end else begin
			tbl_we    = sched_start;
			tbl_waddr = '0;
			tbl_wdata = key_q[0];
		end
	end

	spk_round u_round (
		.rin  (rnd_in),
		.rout (rnd_out)
	);

	spk_key_store #(
		.WIDTH (spk_pkg::WORD_W),
		.DEPTH (NUM_ROUNDS)
	) u_keys (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	// control and key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sched_ok_q  <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < spk_pkg::KEY_WORDS; i++) begin
				key_q[i] <= '0;
			end
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_we) begin
				key_q[cfg_index] <= cfg_data;
				sched_ok_q       <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (sched_start) begin
						cnt_q <= '0;
						if (NUM_ROUNDS == 1) begin
							sched_ok_q <= 1'b1;
						end else begin
							state_q <= ST_SCHED;
						end
					end else if (in_fire) begin
						cnt_q   <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_SCHED: begin
					if (cfg_we) begin
						// key changed mid-expansion: start over
						state_q <= ST_IDLE;
					end else if (cnt_q == SCHED_END) begin
						sched_ok_q <= 1'b1;
						state_q    <= ST_IDLE;
					end else begin
						cnt_q <= cnt_inc;
					end
				end
				ST_RUN: begin
					if (cnt_q == CNT_LAST) begin
						if (out_free) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_HOLD;
						end
					end else begin
						cnt_q <= cnt_inc;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (sched_start) begin
			cur_q <= key_q[0];
			for (int i = 0; i < spk_pkg::KEY_WORDS - 1; i++) begin
				lw_q[i] <= key_q[i + 1];
			end
		end else if (state_q == ST_SCHED) begin
			// rotate the key words so lw_q[0] is always the one in use
			cur_q <= rnd_out.lo;
			for (int i = 0; i < spk_pkg::KEY_WORDS - 2; i++) begin
				lw_q[i] <= lw_q[i + 1];
			end
			lw_q[spk_pkg::KEY_WORDS - 2] <= rnd_out.hi;
		end

		if (in_fire) begin
			dec_q <= in_ch.action;
			lo_q  <= in_ch.word0;
			hi_q  <= in_ch.word1;
		end else if (state_q == ST_RUN) begin
			lo_q <= rnd_out.lo;
			hi_q <= rnd_out.hi;
		end

		if (state_q == ST_RUN && cnt_q == CNT_LAST && out_free) begin
			ow0_q <= rnd_out.lo;
			ow1_q <= rnd_out.hi;
		end else if (state_q == ST_HOLD && out_free) begin
			ow0_q <= lo_q;
			ow1_q <= hi_q;
		end
	end

endmodule

[sv/spk_checker.sv]
// ----------------------------------------------------------------------------
// spk_checker
// Port-level checks for the cipher block, bound to the top level.
// ----------------------------------------------------------------------------
module spk_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input spk_pkg::word_t out_word0,
	input spk_pkg::word_t out_word1,
	input logic           cfg_we
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word0) && $stable(out_word1))
		else $error("stalled result word changed");

	// one block in flight: no accept right after an accept
	a_one_block: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a block is in flight");

	// a key write makes the round keys stale
	a_key_stale: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !in_ready)
		else $error("input ready right after a key write");

	// a result only appears at the end of a run, never from an idle engine
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared while the engine was idle");

endmodule

bind speck32_64_block_cipher spk_checker u_spk_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_word0 (out_ch.out_word0),
	.out_word1 (out_ch.out_word1),
	.cfg_we    (cfg_we)
);

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Speck32/64 cipher: keys are loaded through the
// config port, blocks go in under random bursts and receiver stalls, and every
// result word is checked against an in-bench round-key schedule and cipher.
// ----------------------------------------------------------------------------
module tb;

	localparam int ROUNDS     = 22;
	localparam int LONG_HOLD  = 400;   // receiver hold-off for the fill-up test
	localparam int IDLE_LIMIT = 3000;  // cycles with no accept or key write before giving up
	localparam int PHASES     = 6;
	localparam int PHASE_ITEMS = 90;

	localparam logic ACT_ENC = 1'b0;
	localparam logic ACT_DEC = 1'b1;

	localparam logic [spk_pkg::CFG_IDX_W-1:0] KEY_REGS [spk_pkg::KEY_WORDS] =
		'{spk_pkg::REG_KEY0, spk_pkg::REG_KEY1, spk_pkg::REG_KEY2, spk_pkg::REG_KEY3};

	typedef struct packed {
		spk_pkg::word_t w0;
		spk_pkg::word_t w1;
	} block_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [spk_pkg::CFG_IDX_W-1:0] cfg_index;
	spk_pkg::word_t                cfg_data;

	spk_in_if  in_ch();
	spk_out_if out_ch();

	speck32_64_block_cipher #(.NUM_ROUNDS(ROUNDS)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// bench copy of the key registers and the expanded round keys
	spk_pkg::word_t key_reg [spk_pkg::KEY_WORDS];
	spk_pkg::word_t round_key [ROUNDS];
	block_t         expected_blocks [$];
	int             mismatches;

	// long receiver hold-off, requested by a test and served by the receiver
	int hold_requests;
	int hold_served;
	int hold_left;

	// clock
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// cipher arithmetic, all modulo 2^16
	// ------------------------------------------------------------------
	function automatic spk_pkg::word_t rot_l(input spk_pkg::word_t v, input int r);
		return (v << r) | (v >> (spk_pkg::WORD_W - r));
	endfunction

	function automatic spk_pkg::word_t rot_r(input spk_pkg::word_t v, input int r);
		return (v >> r) | (v << (spk_pkg::WORD_W - r));
	endfunction

	// standard speck schedule: the l words run through the round function
	// with the round counter standing in for the key
	function automatic void expand_round_keys();
		spk_pkg::word_t k;
		spk_pkg::word_t l [spk_pkg::KEY_WORDS-1];
		spk_pkg::word_t h;
		int             j;
		k = key_reg[0];
		for (int i = 0; i < spk_pkg::KEY_WORDS - 1; i++) l[i] = key_reg[i+1];
		round_key[0] = k;
		for (int i = 0; i + 1 < ROUNDS; i++) begin
			j = i % (spk_pkg::KEY_WORDS - 1);
			h = (rot_r(l[j], spk_pkg::ALPHA) + k) ^ spk_pkg::word_t'(i);
			k = rot_l(k, spk_pkg::BETA) ^ h;
			l[j] = h;
			round_key[i+1] = k;
		end
	endfunction

	// word0 is the low half (rotated left by beta when encrypting), word1 the high half
	function automatic block_t cipher_block(input logic act, input spk_pkg::word_t w0,
		input spk_pkg::word_t w1);
		spk_pkg::word_t lo;
		spk_pkg::word_t hi;
		spk_pkg::word_t t;
		lo = w0;
		hi = w1;
		if (act == ACT_ENC) begin
			for (int i = 0; i < ROUNDS; i++) begin
				t  = (rot_r(hi, spk_pkg::ALPHA) + lo) ^ round_key[i];
				lo = rot_l(lo, spk_pkg::BETA) ^ t;
				hi = t;
			end
		end else begin
			// inverse rounds, keys taken from the last one down
			for (int i = 0; i < ROUNDS; i++) begin
				t  = rot_r(lo ^ hi, spk_pkg::BETA);
				hi = rot_l((hi ^ round_key[ROUNDS-1-i]) - t, spk_pkg::ALPHA);
				lo = t;
			end
		end
		return '{w0: lo, w1: hi};
	endfunction

	// biased toward the corners so every key and data bit sees both values
	function automatic spk_pkg::word_t pick_word();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2:       return spk_pkg::word_t'(1) << $urandom_range(0, spk_pkg::WORD_W - 1);
			3:       return ~(spk_pkg::word_t'(1) << $urandom_range(0, spk_pkg::WORD_W - 1));
			default: return spk_pkg::word_t'($urandom);
		endcase
	endfunction

	// ------------------------------------------------------------------
	// config port: one key word per edge, we kept high across a group
	// ------------------------------------------------------------------
	task automatic write_key(input int idx, input spk_pkg::word_t val);
		cfg_we    <= 1'b1;
		cfg_index <= KEY_REGS[idx];
		cfg_data  <= val;
		key_reg[idx] = val;
		@(posedge clk);
	endtask

	// close a group of writes; the block rebuilds its schedule from here
	task automatic end_key_writes();
		cfg_we <= 1'b0;
		expand_round_keys();
	endtask

	task automatic load_key(input spk_pkg::word_t k0, input spk_pkg::word_t k1,
		input spk_pkg::word_t k2, input spk_pkg::word_t k3);
		write_key(0, k0);
		write_key(1, k1);
		write_key(2, k2);
		write_key(3, k3);
		end_key_writes();
	endtask

	// ------------------------------------------------------------------
	// sender side: valid stays high from one word to the next, only a gap
	// or a drain lowers it
	// ------------------------------------------------------------------
	task automatic send_block(input logic act, input spk_pkg::word_t w0,
		input spk_pkg::word_t w1);
		in_ch.valid  <= 1'b1;
		in_ch.action <= act;
		in_ch.word0  <= w0;
		in_ch.word1  <= w1;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		expected_blocks.push_back(cipher_block(act, w0, w1));
	endtask

	task automatic idle_gap(input int cycles);
		if (cycles > 0) begin
			in_ch.valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// every word yields a result, so an empty queue means the block is idle
	task automatic wait_drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_blocks.size() != 0) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// keys straight out of reset (all zero); the first word also has to wait
	// for the schedule built after reset
	task automatic test_reset_key();
		send_block(ACT_ENC, 16'h0000, 16'h0000);
		send_block(ACT_DEC, 16'h0000, 16'h0000);
		send_block(ACT_ENC, 16'hffff, 16'hffff);
		send_block(ACT_DEC, 16'h1234, 16'hfedc);
		wait_drain();
	endtask

	// published speck32/64 vector: encrypt the plaintext, decrypt the cipher
	task automatic test_known_vector();
		load_key(16'h0100, 16'h0908, 16'h1110, 16'h1918);
		send_block(ACT_ENC, 16'h694c, 16'h6574);
		send_block(ACT_DEC, 16'h42f2, 16'ha868);
		wait_drain();
	endtask

	// all-ones key, data corners for both directions, back to back
	task automatic test_corners();
		spk_pkg::word_t corner [2];
		corner[0] = '0;
		corner[1] = '1;
		load_key('1, '1, '1, '1);
		for (int a = 0; a < 2; a++)
			for (int i = 0; i < 2; i++)
				for (int j = 0; j < 2; j++)
					send_block(a ? ACT_DEC : ACT_ENC, corner[i], corner[j]);
		send_block(ACT_ENC, 16'h8000, 16'h0001);
		send_block(ACT_DEC, 16'h0001, 16'h8000);
		wait_drain();
	endtask

	// a lone key write must still make the schedule stale; send at once
	task automatic test_single_key_write();
		write_key(2, 16'h5a5a);
		end_key_writes();
		send_block(ACT_ENC, 16'hc3c3, 16'h3c3c);
		send_block(ACT_DEC, 16'hc3c3, 16'h3c3c);
		wait_drain();
	endtask

	// receiver holds off while the sender keeps offering words; the engine
	// and the output register fill up and ready on the input has to drop
	task automatic test_fill_up();
		load_key(pick_word(), pick_word(), pick_word(), pick_word());
		hold_requests++;
		for (int i = 0; i < 8; i++)
			send_block($urandom_range(0, 1) ? ACT_DEC : ACT_ENC, pick_word(), pick_word());
		wait_drain();
	endtask

	// random phases: a new key (sometimes only part of it) then bursts of
	// words; some are round trips, encrypt then decrypt of its result
	task automatic test_random_traffic();
		block_t         ct;
		spk_pkg::word_t p0;
		spk_pkg::word_t p1;
		int             mask;
		int             sent;
		int             burst;
		bit             no_gaps;
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == 0) begin
				load_key('0, '1, '0, '1);
			end else begin
				mask = (ph % 2) ? 15 : $urandom_range(1, 15);
				for (int i = 0; i < spk_pkg::KEY_WORDS; i++)
					if (mask[i]) write_key(i, pick_word());
				end_key_writes();
			end
			no_gaps = (ph == 2);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				burst = $urandom_range(1, 8);
				for (int b = 0; b < burst; b++) begin
					p0 = pick_word();
					p1 = pick_word();
					if ($urandom_range(0, 6) == 0) begin
						ct = cipher_block(ACT_ENC, p0, p1);
						send_block(ACT_ENC, p0, p1);
						send_block(ACT_DEC, ct.w0, ct.w1);
						sent += 2;
					end else begin
						send_block($urandom_range(0, 1) ? ACT_DEC : ACT_ENC, p0, p1);
						sent++;
					end
				end
				// gaps up to past one block time so they land on every round
				if (!no_gaps && $urandom_range(0, 3) != 0)
					idle_gap($urandom_range(1, 2 * ROUNDS));
			end
			wait_drain();
		end
	endtask

	// ------------------------------------------------------------------
	// receiver: a rotating stall pattern that is redrawn now and then,
	// overridden by a long hold-off on request
	// ------------------------------------------------------------------
	logic [15:0] stall_pattern;
	int          pattern_age;

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else if (hold_served != hold_requests) begin
			hold_served++;
			hold_left = LONG_HOLD;
			out_ch.ready <= 1'b0;
		end else begin
			if (pattern_age == 0) begin
				case ($urandom_range(0, 3))
					0:       stall_pattern = '1;
					1:       stall_pattern = 16'($urandom);
					2:       stall_pattern = 16'($urandom) | 16'($urandom);
					default: stall_pattern = 16'($urandom) & 16'($urandom);
				endcase
				if (stall_pattern == '0) stall_pattern = 16'h0001;
				pattern_age = $urandom_range(32, 160);
			end
			pattern_age--;
			stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
			out_ch.ready <= stall_pattern[0];
		end
	end

	// ------------------------------------------------------------------
	// result checker: oldest expectation against each accepted result word
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		block_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_blocks.size() == 0) begin
				$display("%0t: result word with nothing expected: word0 %h word1 %h",
					$time, out_ch.out_word0, out_ch.out_word1);
				mismatches++;
			end else begin
				want = expected_blocks.pop_front();
				if (out_ch.out_word0 !== want.w0) begin
					$display("%0t: out_word0 expected %h actual %h",
						$time, want.w0, out_ch.out_word0);
					mismatches++;
				end
				if (out_ch.out_word1 !== want.w1) begin
					$display("%0t: out_word1 expected %h actual %h",
						$time, want.w1, out_ch.out_word1);
					mismatches++;
				end
			end
		end
	end

	// watchdog: any accept or key write resets the count
	int quiet_cycles;

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		hold_requests = 0;
		for (int i = 0; i < spk_pkg::KEY_WORDS; i++) key_reg[i] = '0;
		expand_round_keys();

		arst_n       <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_index    <= spk_pkg::REG_KEY0;
		cfg_data     <= '0;
		in_ch.valid  <= 1'b0;
		in_ch.action <= ACT_ENC;
		in_ch.word0  <= '0;
		in_ch.word1  <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_key();
		test_known_vector();
		test_corners();
		test_single_key_write();
		test_fill_up();
		test_random_traffic();

		// let anything stray come out before the verdict
		repeat (3 * ROUNDS) @(posedge clk);
		if (mismatches == 0 && expected_blocks.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

[speck32_64_block_cipher.f]
sv/spk_pkg.sv
sv/spk_if.sv
sv/spk_round.sv
sv/spk_key_store.sv
sv/speck32_64_block_cipher.sv
sv/spk_checker.sv
tb/tb.sv
